>>> rtl/core/assert_macros.svh
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off during reset
`define RFPW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence checked in the clock cycle after the antecedent
`define RFPW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rfpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfpw_pkg
// shared types and constants of the pulse-width remote code decoder
// ----------------------------------------------------------------------------
package rfpw_pkg;

   localparam int TIME_W        = 32;
   localparam int CODE_W        = 32;
   localparam int LIMIT_W       = 16;
   localparam int LIGHT_W       = 8;
   localparam int MATCH_INDEX_W = 2;
   localparam int MAX_CODES     = 4;
   localparam int NUM_CODES_DEFAULT = 4;
   localparam int QUEUE_DEPTH   = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 40;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_MIN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_MAX    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ENTRY_ZERO  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ENTRY_ONE   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ENTRY_TWO   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ENTRY_THREE = 3'd7;

   localparam logic [LIGHT_W-1:0] NO_LIGHT = 8'hFF;

   localparam logic [LIMIT_W-1:0] SYNC_MIN_RESET    = 16'd9000;
   localparam logic [LIMIT_W-1:0] SYNC_MAX_RESET    = 16'd11000;
   localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RESET = 16'd500;
   localparam logic [LIMIT_W-1:0] LONG_LIMIT_RESET  = 16'd1500;

   typedef struct packed {
      logic [LIMIT_W-1:0] sync_min;
      logic [LIMIT_W-1:0] sync_max;
      logic [LIMIT_W-1:0] short_limit;
      logic [LIMIT_W-1:0] long_limit;
   } timing_cfg_type;

   // same bit layout as the register: light id on top, code below
   typedef struct packed {
      logic [LIGHT_W-1:0] light;
      logic [CODE_W-1:0]  code;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } code_rec_type;

   typedef struct packed {
      logic                     found;
      logic [MATCH_INDEX_W-1:0] index;
      logic [LIGHT_W-1:0]       light;
      logic                     toggle;
      logic [CODE_W-1:0]        code;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/core/rf_pulse_width_code_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rf_pulse_width_code_decoder
// pulse-width remote code decoder with a four-entry code table
// ----------------------------------------------------------------------------
// usage
//  - req channel: one request per received edge, carrying its microsecond
//    timestamp; taken when req_valid is high and req_stall is low
//  - gaps between edges shift 0 or 1 bits into a 32-bit code word; a sync gap
//    closes the word and produces one rsp with the code and its table match
//  - edges that are not sync gaps produce no rsp
//  - throughput: one request per cycle while req_stall is low; the intake
//    does the subtract, compares and shift combinationally
//  - a taken sync edge's code word is registered in the queue, then in the
//    output register of the matcher, before it shows on rsp
//  - a two-deep queue parts intake and matcher; req_stall rises only when it
//    is full, i.e. while rsp has been stalled for a while
//  - rsp_stall holds the result steady; nothing is dropped
//  - user must make csr writes only while the block is idle (not enforced)
//  - reset (synchronous): timing limits and table return to defaults, code
//    word and last edge time clear to zero, queue and output empty
// ----------------------------------------------------------------------------
module rf_pulse_width_code_decoder import rfpw_pkg::*; #(
   parameter int NUM_CODES = NUM_CODES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [TIME_W-1:0]        req_edge_time_us,
   // result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [CODE_W-1:0]             rsp_received_code,
   output logic                          rsp_match_found,
   output logic [MATCH_INDEX_W-1:0]      rsp_match_index,
   output logic [LIGHT_W-1:0]            rsp_light_id,
   output logic                          rsp_toggle_light,
   // register write port
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_write_data
);

   timing_cfg_type timing_ff;
   entry_type      entries_ff [MAX_CODES];
   logic           req_accept;
   code_rec_type   push;
   code_rec_type   head;
   logic           pop;
   logic           queue_full;
   result_type     rsp_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.sync_min    <= SYNC_MIN_RESET;
         timing_ff.sync_max    <= SYNC_MAX_RESET;
         timing_ff.short_limit <= SHORT_LIMIT_RESET;
         timing_ff.long_limit  <= LONG_LIMIT_RESET;
         for (int k = 0; k < MAX_CODES; k++) begin
            entries_ff[k] <= '{light: NO_LIGHT, code: '0};
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SYNC_MIN:    timing_ff.sync_min    <= csr_write_data[LIMIT_W-1:0];
            REG_SYNC_MAX:    timing_ff.sync_max    <= csr_write_data[LIMIT_W-1:0];
            REG_SHORT_LIMIT: timing_ff.short_limit <= csr_write_data[LIMIT_W-1:0];
            REG_LONG_LIMIT:  timing_ff.long_limit  <= csr_write_data[LIMIT_W-1:0];
            REG_ENTRY_ZERO:  entries_ff[0] <= entry_type'(csr_write_data);
            REG_ENTRY_ONE:   entries_ff[1] <= entry_type'(csr_write_data);
            REG_ENTRY_TWO:   entries_ff[2] <= entry_type'(csr_write_data);
            REG_ENTRY_THREE: entries_ff[3] <= entry_type'(csr_write_data);
            default: begin
            end
         endcase
      end
   end

   // intake stalls only when no room is left for a finished code word
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   rfpw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .edge_time (req_edge_time_us),
      .timing    (timing_ff),
      .push      (push)
   );

   rfpw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (push),
      .pop   (pop),
      .rd    (head),
      .full  (queue_full)
   );

   rfpw_back #(
      .NUM_CODES (NUM_CODES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .rd        (head),
      .pop       (pop),
      .entries   (entries_ff),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_received_code = rsp_data.code;
   assign rsp_match_found   = rsp_data.found;
   assign rsp_match_index   = rsp_data.index;
   assign rsp_light_id      = rsp_data.light;
   assign rsp_toggle_light  = rsp_data.toggle;

endmodule
`default_nettype wire

>>> rtl/core/rfpw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfpw_front
// edge intake: gap measurement, gap classification and code accumulation
// ----------------------------------------------------------------------------
module rfpw_front import rfpw_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [TIME_W-1:0] edge_time,
   input  wire timing_cfg_type    timing,
   output code_rec_type           push
);

   logic [TIME_W-1:0] last_ff, last_in;
   logic [CODE_W-1:0] shift_ff, shift_in;
   logic [TIME_W-1:0] gap;
   logic              is_sync;
   logic              is_zero;
   logic              is_one;
   logic [CODE_W-1:0] base;

   always_comb begin
      gap     = edge_time - last_ff;
      is_sync = (gap > TIME_W'(timing.sync_min)) && (gap < TIME_W'(timing.sync_max));
      is_zero = gap < TIME_W'(timing.short_limit);
      is_one  = (gap > TIME_W'(timing.short_limit)) && (gap < TIME_W'(timing.long_limit));
      base    = is_sync ? '0 : shift_ff;
      if (is_zero) begin
         shift_in = {base[CODE_W-2:0], 1'b0};
      end else if (is_one) begin
         shift_in = {base[CODE_W-2:0], 1'b1};
      end else begin
         shift_in = base;
      end
      last_in    = edge_time;
      push.valid = accept && is_sync;
      push.code  = shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         shift_ff <= '0;
      end else if (accept) begin
         last_ff  <= last_in;
         shift_ff <= shift_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/rfpw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rfpw_queue
// short fifo of finished code words between intake and matcher
// ----------------------------------------------------------------------------
module rfpw_queue import rfpw_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire code_rec_type wr,
   input  wire logic         pop,
   output code_rec_type      rd,
   output logic              full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [CODE_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      do_push   = wr.valid && !full;
      do_pop    = pop && rd.valid;
      wr_ptr_in = do_push ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign full     = (count_ff == FULL_CNT);
   assign rd.valid = (count_ff != '0);
   assign rd.code  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr.code;
      end
   end

   `RFPW_ASSERT(a_no_drop, clock, reset, !(wr.valid && full), "code word pushed into full queue")
   `RFPW_ASSERT_NEXT(a_count_up, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "queue count did not rise on push")
   `RFPW_ASSERT(a_count_range, clock, reset, count_ff <= FULL_CNT, "queue count beyond depth")

endmodule
`default_nettype wire

>>> rtl/core/rfpw_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rfpw_back
// code table match and output register
// ----------------------------------------------------------------------------
module rfpw_back import rfpw_pkg::*; #(
   parameter int NUM_CODES = NUM_CODES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire code_rec_type rd,
   output logic              pop,
   input  wire entry_type    entries [MAX_CODES],
   input  wire logic         out_stall,
   output logic              out_valid,
   output result_type        out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // lowest matching active entry wins
   always_comb begin
      data_in.found  = 1'b0;
      data_in.index  = '0;
      data_in.light  = NO_LIGHT;
      data_in.toggle = 1'b0;
      data_in.code   = rd.code;
      for (int k = NUM_CODES - 1; k >= 0; k--) begin
         if (entries[k].code == rd.code) begin
            data_in.found  = 1'b1;
            data_in.index  = MATCH_INDEX_W'(k);
            data_in.light  = entries[k].light;
            data_in.toggle = (entries[k].light != NO_LIGHT);
         end
      end
   end

   always_comb begin
      pop      = rd.valid && (!valid_ff || !out_stall);
      valid_in = pop || (valid_ff && out_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   `RFPW_ASSERT(a_nomatch_fields, clock, reset, !(valid_ff && !data_ff.found) || (data_ff.light == NO_LIGHT && data_ff.index == '0 && !data_ff.toggle), "unmatched result carries match fields")
   `RFPW_ASSERT_NEXT(a_hold_on_stall, clock, reset, valid_ff && out_stall, valid_ff && data_ff == $past(data_ff), "result lost while stalled")
   `RFPW_ASSERT(a_pop_when_valid, clock, reset, !pop || rd.valid, "pop from empty queue")

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pulse-width remote code decoder: edges are sent
// as requests with microsecond timestamps, a local model of the gap decoder
// and code table predicts each sync result, and every rsp is compared field by
// field while both sides stall at random
// ----------------------------------------------------------------------------
module tb_top;
   import rfpw_pkg::*;

   localparam int HOLD_OFF_CYCLES = 400;   // long rsp hold-off to fill the block
   localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES   = 4;
   localparam int MAX_PRINTS      = 50;

   // kinds of gap the stimulus asks for, resolved against the current limits
   typedef enum {GAP_ZERO, GAP_ONE, GAP_SYNC, GAP_NOISE} gap_kind_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [TIME_W-1:0]        req_edge_time_us;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [CODE_W-1:0]        rsp_received_code;
   logic                     rsp_match_found;
   logic [MATCH_INDEX_W-1:0] rsp_match_index;
   logic [LIGHT_W-1:0]       rsp_light_id;
   logic                     rsp_toggle_light;
   logic                     csr_write_enable;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_write_data;

   // local copy of the decoder: timing limits, code table, last edge, code word
   logic [LIMIT_W-1:0] lim_sync_min;
   logic [LIMIT_W-1:0] lim_sync_max;
   logic [LIMIT_W-1:0] lim_short;
   logic [LIMIT_W-1:0] lim_long;
   entry_type          code_table [MAX_CODES];
   logic [TIME_W-1:0]  last_edge_us;
   logic [CODE_W-1:0]  code_word;

   result_type         pending_results [$];  // predicted decodes, oldest first
   logic [TIME_W-1:0]  edge_now_us;          // timeline of the edges sent so far
   int                 requests_sent;
   int                 mismatch_count;
   bit                 quiet_tail;           // no idling on either side
   bit                 hold_off_request;     // asks the rsp side for a long stall

   rf_pulse_width_code_decoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_edge_time_us  (req_edge_time_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_received_code (rsp_received_code),
      .rsp_match_found   (rsp_match_found),
      .rsp_match_index   (rsp_match_index),
      .rsp_light_id      (rsp_light_id),
      .rsp_toggle_light  (rsp_toggle_light),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------------

   // one accepted edge: classify the gap, close the word on sync, shift a bit
   function automatic void decode_edge(input logic [TIME_W-1:0] edge_us);
      logic [TIME_W-1:0] gap_us;
      result_type        r;
      int                k;
      gap_us = edge_us - last_edge_us;  // wraps modulo 2^32
      if (gap_us > lim_sync_min && gap_us < lim_sync_max) begin
         r.code  = code_word;
         r.found = 1'b0;
         r.index = '0;
         r.light = NO_LIGHT;
         // scan from the top so the lowest matching entry wins
         for (k = MAX_CODES - 1; k >= 0; k--) begin
            if (code_table[k].code == code_word) begin
               r.found = 1'b1;
               r.index = MATCH_INDEX_W'(k);
               r.light = code_table[k].light;
            end
         end
         r.toggle = r.found && (r.light != NO_LIGHT);
         pending_results.push_back(r);
         code_word = '0;
      end
      // bit classification sees the same gap, even right after a sync
      if (gap_us < lim_short)
         code_word = {code_word[CODE_W-2:0], 1'b0};
      if (gap_us > lim_short && gap_us < lim_long)
         code_word = {code_word[CODE_W-2:0], 1'b1};
      last_edge_us = edge_us;
   endfunction

   // a gap of the wanted kind under the current limits; an empty range falls
   // back to a gap equal to the short limit, which shifts nothing
   function automatic logic [TIME_W-1:0] pick_gap(input gap_kind_type kind);
      int short_us;
      int long_us;
      int sync_lo;
      int sync_hi;
      short_us = int'(lim_short);
      long_us  = int'(lim_long);
      sync_lo  = int'(lim_sync_min);
      sync_hi  = int'(lim_sync_max);
      case (kind)
         GAP_ZERO: begin
            if (short_us > 0)
               return $urandom_range(0, short_us - 1);
         end
         GAP_ONE: begin
            if (long_us > short_us + 1)
               return $urandom_range(short_us + 1, long_us - 1);
         end
         GAP_SYNC: begin
            if (sync_hi > sync_lo + 1)
               return $urandom_range(sync_lo + 1, sync_hi - 1);
         end
         default: begin
            // noise: exact bounds, anything in 16 bits, or a huge jump
            case ($urandom_range(0, 5))
               0:       return TIME_W'(lim_short);
               1:       return TIME_W'(lim_long);
               2:       return TIME_W'(lim_sync_min);
               3:       return TIME_W'(lim_sync_max);
               4:       return $urandom;
               default: return $urandom_range(0, 65535);
            endcase
         end
      endcase
      return TIME_W'(lim_short);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // register write at one clock edge; the model takes the value masked to
   // the register width
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         REG_SYNC_MIN:    lim_sync_min = data[LIMIT_W-1:0];
         REG_SYNC_MAX:    lim_sync_max = data[LIMIT_W-1:0];
         REG_SHORT_LIMIT: lim_short    = data[LIMIT_W-1:0];
         REG_LONG_LIMIT:  lim_long     = data[LIMIT_W-1:0];
         default:         code_table[MATCH_INDEX_W'(idx - REG_ENTRY_ZERO)] = data;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // limit writes carry random junk above bit 15, which must be dropped
   task automatic set_timing(input int sync_lo, input int sync_hi,
                             input int short_us, input int long_us);
      write_reg(REG_SYNC_MIN,    {24'($urandom), 16'(sync_lo)});
      write_reg(REG_SYNC_MAX,    {24'($urandom), 16'(sync_hi)});
      write_reg(REG_SHORT_LIMIT, {24'($urandom), 16'(short_us)});
      write_reg(REG_LONG_LIMIT,  {24'($urandom), 16'(long_us)});
   endtask

   // table with small codes (hit by short words), repeats and full-width codes
   task automatic randomize_table();
      int                k;
      logic [CODE_W-1:0]  code;
      logic [LIGHT_W-1:0] light;
      for (k = 0; k < MAX_CODES; k++) begin
         case ($urandom_range(0, 3))
            0:       code = $urandom_range(0, 15);
            1:       code = (k > 0) ? code_table[k-1].code : '1;
            default: code = $urandom;
         endcase
         light = ($urandom_range(0, 3) == 0) ? NO_LIGHT : LIGHT_W'($urandom);
         write_reg(CSR_INDEX_W'(int'(REG_ENTRY_ZERO) + k), {light, code});
      end
   endtask

   // one edge request; the payload holds until the block takes it
   task automatic send_edge_at(input logic [TIME_W-1:0] edge_us);
      int idle_cycles;
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         idle_cycles = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (idle_cycles) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_edge_time_us <= edge_us;
      edge_now_us       = edge_us;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_edge(edge_us);
      requests_sent++;
   endtask

   task automatic send_gap(input logic [TIME_W-1:0] gap_us);
      send_edge_at(edge_now_us + gap_us);
   endtask

   // drop valid, wait for every predicted result, then let the pipe empty
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // code words: mostly bit runs closed by a sync, with table codes sent in
   // full (sometimes with extra leading bits that overflow), short random
   // words, occasional noise between words and broken words
   task automatic run_traffic(input int n_items);
      int                stop_at;
      int                nbits;
      int                b;
      logic [CODE_W-1:0] word;
      stop_at = requests_sent + n_items;
      while (requests_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) send_gap(pick_gap(GAP_NOISE));
         if ($urandom_range(0, 4) < 2) begin
            word  = code_table[$urandom_range(0, MAX_CODES - 1)].code;
            nbits = CODE_W + $urandom_range(0, 3);
         end else begin
            word  = $urandom;
            nbits = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12);
         end
         for (b = nbits - 1; b >= 0; b--) begin
            if ($urandom_range(0, 29) == 0)
               send_gap(pick_gap(GAP_NOISE));
            if ((b < CODE_W) ? word[b] : ($urandom_range(0, 1) == 1))
               send_gap(pick_gap(GAP_ONE));
            else
               send_gap(pick_gap(GAP_ZERO));
         end
         send_gap(pick_gap(GAP_SYNC));
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset limits and table: the first gap counts from time zero, and a zero
   // code word matches entry zero with no light
   task automatic test_reset_state();
      send_edge_at(32'd0);
      send_edge_at(32'd10000);
      settle_block();
   endtask

   // exact bounds, lowest index on duplicate codes, light zero and no light,
   // timestamp wrap, and a sync range overlapping the one-bit range
   task automatic test_boundaries();
      write_reg(REG_ENTRY_ZERO,  {8'd3,    32'd5});
      write_reg(REG_ENTRY_ONE,   {8'd7,    32'd5});
      write_reg(REG_ENTRY_TWO,   {NO_LIGHT, 32'hFFFF_FFFF});
      write_reg(REG_ENTRY_THREE, {8'd0,    32'd0});
      // code 101 hits entry zero ahead of entry one
      send_gap(32'd1000);
      send_gap(32'd100);
      send_gap(32'd1499);
      send_gap(32'd10000);
      // gaps on every bound change nothing; code 10 matches no entry
      send_gap(32'd500);
      send_gap(32'd501);
      send_gap(32'd9000);
      send_gap(32'd11000);
      send_gap(32'd1500);
      send_gap(32'd499);
      send_gap(32'd9001);
      // sync gap that crosses the timestamp wrap
      send_edge_at(32'hFFFF_FFF0);
      send_edge_at(32'd9990);
      settle_block();
      // a gap that is both sync and one-bit closes the word, then shifts a 1
      set_timing(400, 2000, 500, 1500);
      send_gap(32'd1000);
      send_gap(32'd1000);
      settle_block();
   endtask

   // rsp held off for a long stretch while sync edges keep coming, so the
   // queue fills and req_stall has to rise
   task automatic test_input_stall();
      set_timing(SYNC_MIN_RESET, SYNC_MAX_RESET, SHORT_LIMIT_RESET, LONG_LIMIT_RESET);
      randomize_table();
      hold_off_request = 1'b1;
      repeat (40) send_gap(pick_gap(GAP_SYNC));
      settle_block();
   endtask

   task automatic test_default_timing();
      set_timing(SYNC_MIN_RESET, SYNC_MAX_RESET, SHORT_LIMIT_RESET, LONG_LIMIT_RESET);
      randomize_table();
      run_traffic(200);
      settle_block();
   endtask

   // widest ranges, then empty sync and one-bit ranges (no sync, no one bits)
   task automatic test_limit_extremes();
      set_timing(0, 65535, 0, 65535);
      randomize_table();
      run_traffic(150);
      settle_block();
      set_timing(65535, 0, 65535, 0);
      run_traffic(50);
      settle_block();
   endtask

   task automatic test_overlapping_ranges();
      set_timing(2000, 2600, 300, 3000);
      randomize_table();
      run_traffic(200);
      settle_block();
   endtask

   // mostly usable ranges at random, once with every limit drawn freely
   task automatic test_random_settings();
      int sync_lo;
      int short_us;
      repeat (2) begin
         sync_lo  = $urandom_range(0, 40000);
         short_us = $urandom_range(1, 3000);
         set_timing(sync_lo, sync_lo + $urandom_range(2, 20000),
                    short_us, short_us + $urandom_range(2, 5000));
         randomize_table();
         run_traffic(150);
         settle_block();
      end
      set_timing($urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      randomize_table();
      run_traffic(150);
      settle_block();
   endtask

   // closing stretch at full rate on both sides
   task automatic test_steady_stream();
      quiet_tail = 1'b1;
      set_timing(SYNC_MIN_RESET, SYNC_MAX_RESET, SHORT_LIMIT_RESET, LONG_LIMIT_RESET);
      randomize_table();
      run_traffic(200);
      settle_block();
   endtask

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // every accepted rsp is compared with the oldest predicted decode
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected rsp, received_code", 64'(rsp_received_code), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_received_code !== want.code)
               report_mismatch("received_code", 64'(rsp_received_code), 64'(want.code));
            if (rsp_match_found !== want.found)
               report_mismatch("match_found", 64'(rsp_match_found), 64'(want.found));
            if (rsp_match_index !== want.index)
               report_mismatch("match_index", 64'(rsp_match_index), 64'(want.index));
            if (rsp_light_id !== want.light)
               report_mismatch("light_id", 64'(rsp_light_id), 64'(want.light));
            if (rsp_toggle_light !== want.toggle)
               report_mismatch("toggle_light", 64'(rsp_toggle_light), 64'(want.toggle));
         end
      end
   end

   // rsp side: random stall bursts and free runs, one long hold-off on request,
   // never a stall in the closing stretch
   initial begin : rsp_stall_driver
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left       = HOLD_OFF_CYCLES;
         end else if (quiet_tail) begin
            stall_left = 0;
            free_left  = 0;
         end else if (stall_left == 0 && free_left == 0) begin
            if ($urandom_range(0, 2) == 0)
               stall_left = $urandom_range(1, 18);
            else
               free_left = $urandom_range(1, 40);
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0)
            stall_left--;
         else if (free_left > 0)
            free_left--;
      end
   end

   // ends the run if nothing moves on any port for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_enable || (req_valid && !req_stall) ||
             (rsp_valid === 1'b1 && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("rf_pulse_width_code_decoder verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      int k;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_edge_time_us = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      quiet_tail       = 1'b0;
      hold_off_request = 1'b0;
      requests_sent    = 0;
      mismatch_count   = 0;
      // model starts from the reset state of the block
      lim_sync_min = SYNC_MIN_RESET;
      lim_sync_max = SYNC_MAX_RESET;
      lim_short    = SHORT_LIMIT_RESET;
      lim_long     = LONG_LIMIT_RESET;
      for (k = 0; k < MAX_CODES; k++)
         code_table[k] = '{light: NO_LIGHT, code: '0};
      last_edge_us = '0;
      code_word    = '0;
      edge_now_us  = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_boundaries();
      test_input_stall();
      test_default_timing();
      test_limit_extremes();
      test_overlapping_ranges();
      test_random_settings();
      test_steady_stream();

      if (mismatch_count == 0)
         $display("rf_pulse_width_code_decoder verification clean");
      else
         $display("rf_pulse_width_code_decoder verification failed");
      $finish;
   end

endmodule
